### rtl/core/glob_wildcard_matcher_core_macros.svh
// Assertion macros for the glob wildcard matcher checker.
// Included by the checker; no other dependencies.
`ifndef GLOB_WILDCARD_MATCHER_CORE_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_CORE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define GWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that stays active through reset.
`define GWM_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/gwm_pkg.sv
// Shared constants and types for the glob wildcard matcher.
// No dependencies.
package gwm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LIVE_W      = PATTERN_MAX + 1;
  localparam int ACTION_W    = 2;
  localparam int CHAR_W      = 8;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_END    = 2'd3;

  // Wildcard symbols
  localparam logic [CHAR_W-1:0] SYM_ANY_ONE = 8'h3F;  // '?'
  localparam logic [CHAR_W-1:0] SYM_ANY_RUN = 8'h2A;  // '*'

  typedef struct packed {
    logic                fire;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_byte;
  } cmd_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

endpackage

### rtl/core/gwm_engine.sv
// Pattern store and live-position set of the glob matcher.
// Depends on gwm_pkg.
module gwm_engine (
  input  logic          clk,
  input  logic          rst,
  input  gwm_pkg::cmd_t cmd,
  output gwm_pkg::res_t res
);
  import gwm_pkg::*;

  logic [CHAR_W-1:0]   store [PATTERN_MAX];
  logic [LEN_W-1:0]    len;
  logic [LIVE_W-1:0]   live;
  logic                overflow;

  logic [LIVE_W-1:0]      star;
  logic [PATTERN_MAX-1:0] hit;
  logic [LIVE_W-1:0]      closed;
  logic [LIVE_W-1:0]      carry_sum;
  logic [LIVE_W-1:0]      live_next;

  localparam logic [LIVE_W-1:0] LIVE_START = LIVE_W'(1);

  // Per-position decode: star, and single-byte step for the incoming char
  always_comb begin
    star = '0;
    hit  = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < len) begin
        star[i] = (store[i] == SYM_ANY_RUN);
        hit[i]  = (store[i] != SYM_ANY_RUN) &&
                  ((store[i] == SYM_ANY_ONE) || (store[i] == cmd.char_byte));
      end
    end
  end

  // Star closure as a carry chain: a live star starts a carry that runs
  // through the rest of its star run and lands one past it.
  assign carry_sum = star + (live & star);
  assign closed    = live | (carry_sum ^ star);

  assign live_next = (closed & star) |
                     {hit & closed[PATTERN_MAX-1:0], 1'b0};

  assign res.matched  = closed[len];
  assign res.overflow = overflow;

  always_ff @(posedge clk) begin
    if (cmd.fire && (cmd.action == ACT_APPEND) && (len < LEN_W'(PATTERN_MAX))) begin
      store[len[IDX_W-1:0]] <= cmd.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      live     <= LIVE_START;
      overflow <= 1'b0;
    end else if (cmd.fire) begin
      case (cmd.action)
        ACT_CLEAR: begin
          len      <= '0;
          overflow <= 1'b0;
          live     <= LIVE_START;
        end
        ACT_APPEND: begin
          if (len < LEN_W'(PATTERN_MAX)) begin
            len <= len + LEN_W'(1);
          end else begin
            overflow <= 1'b1;
          end
          live <= LIVE_START;
        end
        ACT_TEXT: begin
          live <= live_next;
        end
        default: begin
          live <= LIVE_START;
        end
      endcase
    end
  end

endmodule

### rtl/core/glob_wildcard_matcher_core.sv
// Glob wildcard matcher: a pattern of up to PATTERN_MAX bytes ('*' matches
// any run including none, '?' one byte, all else exact and case-sensitive)
// is loaded by append requests and held; text bytes then stream in and an
// end-of-text request returns one result: matched, plus a flag that says
// pattern bytes past capacity were dropped since the last clear. Clear,
// append and end-of-text all restart the text. One request is taken every
// cycle while the result port does not stall. A taken request is held in
// the input register and applied to the engine from there; the edge that
// applies an end-of-text request also loads the result register and raises
// rsp_valid. The result is held back only while the result port stalls,
// and then a held end-of-text request also holds off new requests. The
// one-request-per-cycle rate rests on the update of the live-position set
// for each text byte, whose star closure is a single carry chain across
// all pattern positions. Depends on gwm_pkg and gwm_engine.
module glob_wildcard_matcher_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [gwm_pkg::ACTION_W-1:0]  action,
  input  logic [gwm_pkg::CHAR_W-1:0]    char_byte,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          matched,
  output logic                          pattern_overflow
);
  import gwm_pkg::*;

  // Input register
  logic                s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic [CHAR_W-1:0]   s1_char;

  logic rsp_free;   // result register can take a new result
  logic s1_go;      // held request is applied to the engine this cycle
  logic s1_is_end;

  cmd_t cmd;
  res_t res;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign s1_is_end = (s1_action == ACT_END);
  // Only an end-of-text request needs room in the result register;
  // everything else retires as soon as it is held.
  assign s1_go     = s1_valid && (!s1_is_end || rsp_free);
  assign req_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_action <= action;
      s1_char   <= char_byte;
    end
  end

  assign cmd.fire      = s1_go;
  assign cmd.action    = s1_action;
  assign cmd.char_byte = s1_char;

  // Engine state advances in request order as each request retires
  gwm_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go && s1_is_end) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_end) begin
      matched          <= res.matched;
      pattern_overflow <= res.overflow;
    end
  end

endmodule

### rtl/core/gwm_checker.sv
// Port-level checks for glob_wildcard_matcher_core, bound to the top level.
// Depends on gwm_pkg and glob_wildcard_matcher_core_macros.svh.
`include "glob_wildcard_matcher_core_macros.svh"

module gwm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [gwm_pkg::ACTION_W-1:0]  action,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          matched,
  input logic                          pattern_overflow
);
  import gwm_pkg::*;

  `GWM_ASSERT_RST(a_rsp_idle_after_rst, clk, $past(rst) |-> !rsp_valid, "result valid after reset")
  `GWM_ASSERT(a_ready_when_free, clk, rst, (!rsp_valid || rsp_ready) |-> req_ready, "request stalled with free result port")
  `GWM_ASSERT(a_end_gives_result, clk, rst, (req_valid && req_ready && action == ACT_END) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid, "end of text gave no result")
  `GWM_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(matched) && $stable(pattern_overflow)), "stalled result changed")

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req_valid),
  .req_ready        (req_ready),
  .action           (action),
  .rsp_valid        (rsp_valid),
  .rsp_ready        (rsp_ready),
  .matched          (matched),
  .pattern_overflow (pattern_overflow)
);
